// ===== rtl/sorted_list_insert_delete_unit_macros.svh =====
// assertion macros for the sorted list insert and delete unit
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLID_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define SLID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed: next-cycle implication");

`endif

// ===== rtl/slid_pkg.sv =====
// shared types and codes for the sorted list insert and delete unit
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_DELETED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef struct packed {
        logic                       ins;
        logic                       del;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/sorted_list_insert_delete_unit.sv =====
// top level: sorted list held in a row of cells, with a registered result stage
//
//  channel | valid   | stall   | fields
//  --------+---------+---------+--------------------
//  input   | i_valid | o_stall | i_op, i_value
//  result  | o_valid | i_stall | o_status, o_count
//
// one transaction per cycle unless o_stall is high; every cell compares and shifts in the same cycle
// the result is registered on acceptance, shown in the following cycle and held while stalled
// input is stalled only while a result waits and the result side stalls
// reset empties the list; entries above the count never match a delete
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_unit
    import slid_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [OP_W-1:0]           i_op,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [STATUS_W-1:0]            o_status,
    output logic [COUNT_W-1:0]             o_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                      r_valid;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    t_status                   r_status;
    t_status                   n_status;
    logic [CW-1:0]             r_out_count;

    logic                      accept;
    logic                      full;
    logic                      found;
    t_cell_ctrl                ctrl;

    logic [CAPACITY-1:0]              occ;
    logic [CAPACITY-1:0]              mv;
    logic [CAPACITY-1:0]              eq;
    logic signed [VALUE_W-1:0]        entry [CAPACITY];

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = r_count == CW'(CAPACITY);
    assign found   = |eq;

    assign ctrl.ins   = accept && (t_op'(i_op) == OP_INSERT) && !full;
    assign ctrl.del   = accept && (t_op'(i_op) == OP_DELETE) && found;
    assign ctrl.value = i_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occ[g] = CW'(g) < r_count;

        slid_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occ        (occ[g]),
            .i_prev_mv    ((g == 0) ? 1'b0 : mv[(g == 0) ? 0 : g - 1]),
            .i_prev_entry (entry[(g == 0) ? 0 : g - 1]),
            .i_next_entry (entry[(g == CAPACITY - 1) ? g : g + 1]),
            .o_mv         (mv[g]),
            .o_eq         (eq[g]),
            .o_entry      (entry[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_NOTFOUND;
        case (t_op'(i_op))
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_status = ST_INSERTED;
                end
            end
            OP_DELETE: begin
                if (found) begin
                    n_count  = r_count - 1'b1;
                    n_status = ST_DELETED;
                end
            end
            OP_CLEAR: begin
                n_count  = '0;
                n_status = ST_CLEARED;
            end
            default: begin
                n_status = ST_NOTFOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_count  = COUNT_W'(r_out_count);

endmodule

`default_nettype wire

// ===== rtl/slid_cell.sv =====
// one list cell: holds an entry, compares it and shifts towards either neighbour
`timescale 1ns / 1ps
`default_nettype none

module slid_cell
    import slid_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire t_cell_ctrl                i_ctrl,
    input  wire logic                      i_occ,
    input  wire logic                      i_prev_mv,
    input  wire logic signed [VALUE_W-1:0] i_prev_entry,
    input  wire logic signed [VALUE_W-1:0] i_next_entry,
    output logic                           o_mv,
    output logic                           o_eq,
    output logic signed [VALUE_W-1:0]      o_entry
);

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;
    logic                      ge;

    assign ge      = r_entry >= i_ctrl.value;
    assign o_mv    = !i_occ || (r_entry > i_ctrl.value);
    assign o_eq    = i_occ && (r_entry == i_ctrl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins && o_mv) begin
            n_entry = i_prev_mv ? i_prev_entry : i_ctrl.value;
        end else if (i_ctrl.del && i_occ && ge) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/slid_checker.sv =====
// port checks for the sorted list insert and delete unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_insert_delete_unit_macros.svh"

module slid_checker
    import slid_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      o_stall,
    input  wire logic [OP_W-1:0]           i_op,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      o_valid,
    input  wire logic                      i_stall,
    input  wire logic [STATUS_W-1:0]       o_status,
    input  wire logic [COUNT_W-1:0]        o_count
);

    logic in_acc;

    assign in_acc = i_valid && !o_stall && (i_value == i_value);

    `SLID_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_count))
    `SLID_ASSERT_NEXT(a_clear_result, i_clk, i_rst_n, in_acc && (i_op == OP_CLEAR), o_valid && (o_status == ST_CLEARED) && (o_count == '0))
    `SLID_ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), o_count == COUNT_W'(CAPACITY))
    `SLID_ASSERT_SAME(a_stall_only_when_held, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

bind sorted_list_insert_delete_unit slid_checker #(
    .CAPACITY (CAPACITY)
) u_slid_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_op     (i_op),
    .i_value  (i_value),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_status (o_status),
    .o_count  (o_count)
);

`default_nettype wire
